### hdl/bfct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfct_pkg: shared types and constants of the best-fit free chunk table
// Opcodes, status codes, sequencer states and the compare flags that pass
// from the shared compare unit to the sequencer.
// ----------------------------------------------------------------------------
package bfct_pkg;

  localparam int unsigned SIZE_BITS       = 32;
  localparam int unsigned START_PORT_BITS = 32;
  localparam int unsigned COUNT_PORT_BITS = 7;
  localparam int unsigned OP_BITS         = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REQUEST = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EVICTED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REQ,
    S_FND,
    S_SHF,
    S_PUT
  } state_e;

  typedef struct packed {
    logic key_gt;
    logic start_eq;
  } cmp_flags_t;

endpackage

### hdl/bfct_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfct_mem: chunk table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfct_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bfct_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfct_alu: shared compare and remainder unit
// Compares the key against the entry just read and forms the remainder of a
// granted chunk.
// ----------------------------------------------------------------------------
module bfct_alu #(
  parameter int unsigned ID_BITS = 32
) (
  input  logic [ID_BITS-1:0]             key_start_i,
  input  logic [bfct_pkg::SIZE_BITS-1:0] key_size_i,
  input  logic [ID_BITS-1:0]             ent_start_i,
  input  logic [bfct_pkg::SIZE_BITS-1:0] ent_size_i,
  output bfct_pkg::cmp_flags_t           flags_o,
  output logic [ID_BITS-1:0]             rem_start_o,
  output logic [bfct_pkg::SIZE_BITS-1:0] rem_size_o
);

  assign flags_o.key_gt   = (key_size_i > ent_size_i);
  assign flags_o.start_eq = (key_start_i == ent_start_i);

  // The remainder start wraps at the block id width.
  assign rem_size_o  = ent_size_i - key_size_i;
  assign rem_start_o = ent_start_i + ID_BITS'(key_size_i);

endmodule

### hdl/best_fit_free_chunk_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_free_chunk_table_unit: sorted free chunk table with best-fit grant
// Holds free chunks sorted by size, largest first, and serves insert, remove
// and best-fit requests one at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows for
// exactly one cycle with result_valid_o and must be taken then, since the
// receiver cannot hold it off. The table sits in a single-port-read memory,
// and the sequencer visits one entry per cycle through it: an insert walks
// the entries behind its slot, a remove walks up to the match and the entries
// after it, and a request walks the entries below the best fit and at most
// the entries after it. busy is low again in the cycle that shows the result.
// ----------------------------------------------------------------------------
module best_fit_free_chunk_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned BLOCK_ID_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [bfct_pkg::OP_BITS-1:0]           opcode_i,
  input  logic [bfct_pkg::START_PORT_BITS-1:0]   chunk_start_i,
  input  logic [bfct_pkg::SIZE_BITS-1:0]         chunk_blocks_i,
  output logic                                   result_valid_o,
  output logic [1:0]                             status_o,
  output logic [bfct_pkg::START_PORT_BITS-1:0]   granted_start_o,
  output logic [bfct_pkg::START_PORT_BITS-1:0]   evicted_start_o,
  output logic [bfct_pkg::SIZE_BITS-1:0]         evicted_blocks_o,
  output logic [bfct_pkg::COUNT_PORT_BITS-1:0]   entry_count_o
);

  localparam int unsigned SW = bfct_pkg::SIZE_BITS;
  localparam int unsigned IW = BLOCK_ID_BITS;
  localparam int unsigned PW = bfct_pkg::START_PORT_BITS;
  localparam int unsigned EW = IW + SW;
  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  bfct_pkg::state_e  state_q, state_d;
  bfct_pkg::op_e     op_q, op_d;
  bfct_pkg::status_e status_q, status_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          reins_q, reins_d;
  logic          done_q, done_d;
  logic [IW-1:0] key_start_q, key_start_d;
  logic [SW-1:0] key_size_q, key_size_d;
  logic [PW-1:0] granted_q, granted_d;
  logic [PW-1:0] ev_start_q, ev_start_d;
  logic [SW-1:0] ev_blocks_q, ev_blocks_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] rd_data;

  logic [IW-1:0] ent_start;
  logic [SW-1:0] ent_size;
  logic [IW-1:0] rem_start;
  logic [SW-1:0] rem_size;
  logic [EW-1:0] key_ent;
  logic [IW-1:0] in_start;

  bfct_pkg::cmp_flags_t flags;

  logic [CW-1:0] ptr_inc, ptr_dec, count_m1;
  logic          ptr_zero, last, full, at_end, count_zero;

  assign ent_start  = rd_data[EW-1:SW];
  assign ent_size   = rd_data[SW-1:0];
  assign key_ent    = {key_start_q, key_size_q};
  assign in_start   = IW'(chunk_start_i);

  assign ptr_inc    = ptr_q + CW'(1);
  assign ptr_dec    = ptr_q - CW'(1);
  assign count_m1   = count_q - CW'(1);
  assign ptr_zero   = (ptr_q == '0);
  assign count_zero = (count_q == '0);
  assign last       = (ptr_inc == count_q);
  assign full       = (count_q == CW'(TABLE_ENTRIES));
  assign at_end     = (ptr_inc == CW'(TABLE_ENTRIES));

  bfct_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  bfct_alu #(
    .ID_BITS (IW)
  ) u_alu (
    .key_start_i (key_start_q),
    .key_size_i  (key_size_q),
    .ent_start_i (ent_start),
    .ent_size_i  (ent_size),
    .flags_o     (flags),
    .rem_start_o (rem_start),
    .rem_size_o  (rem_size)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfct_pkg::S_IDLE: begin
        if (start) begin
          unique case (bfct_pkg::op_e'(opcode_i))
            bfct_pkg::OP_INSERT:  state_d = count_zero ? bfct_pkg::S_IDLE : bfct_pkg::S_INS;
            bfct_pkg::OP_REMOVE:  state_d = count_zero ? bfct_pkg::S_IDLE : bfct_pkg::S_FND;
            bfct_pkg::OP_REQUEST: state_d = count_zero ? bfct_pkg::S_IDLE : bfct_pkg::S_REQ;
            default:              state_d = bfct_pkg::S_IDLE;
          endcase
        end
      end
      bfct_pkg::S_INS: begin
        priority if (flags.key_gt && ptr_zero) state_d = bfct_pkg::S_PUT;
        else if (flags.key_gt)                 state_d = bfct_pkg::S_INS;
        else                                   state_d = bfct_pkg::S_IDLE;
      end
      bfct_pkg::S_REQ: begin
        priority if (!flags.key_gt) state_d = last ? bfct_pkg::S_IDLE : bfct_pkg::S_SHF;
        else if (ptr_zero)          state_d = bfct_pkg::S_IDLE;
        else                        state_d = bfct_pkg::S_REQ;
      end
      bfct_pkg::S_FND: begin
        priority if (last)         state_d = bfct_pkg::S_IDLE;
        else if (flags.start_eq)   state_d = bfct_pkg::S_SHF;
        else                       state_d = bfct_pkg::S_FND;
      end
      bfct_pkg::S_SHF: begin
        priority if (reins_q && flags.key_gt) state_d = bfct_pkg::S_IDLE;
        else if (last)                        state_d = reins_q ? bfct_pkg::S_PUT
                                                                : bfct_pkg::S_IDLE;
        else                                  state_d = bfct_pkg::S_SHF;
      end
      bfct_pkg::S_PUT: state_d = bfct_pkg::S_IDLE;
      default:         state_d = bfct_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d        = op_q;
    status_d    = status_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    reins_d     = reins_q;
    done_d      = 1'b0;
    key_start_d = key_start_q;
    key_size_d  = key_size_q;
    granted_d   = granted_q;
    ev_start_d  = ev_start_q;
    ev_blocks_d = ev_blocks_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_inc[AW-1:0];
    mem_wdata   = rd_data;
    mem_raddr   = ptr_dec[AW-1:0];

    unique case (state_q)
      bfct_pkg::S_IDLE: begin
        if (start) begin
          op_d        = bfct_pkg::op_e'(opcode_i);
          key_start_d = in_start;
          key_size_d  = chunk_blocks_i;
          status_d    = bfct_pkg::ST_OK;
          granted_d   = '0;
          ev_start_d  = '0;
          ev_blocks_d = '0;
          reins_d     = 1'b0;
          mem_raddr   = count_m1[AW-1:0];
          ptr_d       = count_m1;
          unique case (bfct_pkg::op_e'(opcode_i))
            bfct_pkg::OP_INSERT: begin
              if (count_zero) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {in_start, chunk_blocks_i};
                count_d   = CW'(1);
                done_d    = 1'b1;
              end
            end
            bfct_pkg::OP_REMOVE: begin
              // The match search runs from the head of the table.
              mem_raddr = '0;
              ptr_d     = '0;
              if (count_zero) begin
                status_d = bfct_pkg::ST_NOT_FOUND;
                done_d   = 1'b1;
              end
            end
            bfct_pkg::OP_REQUEST: begin
              if (count_zero) begin
                status_d = bfct_pkg::ST_NO_FIT;
                done_d   = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      // Walk from the tail, moving each smaller entry one slot back until the
      // new chunk's slot is found. An entry pushed past the end is evicted.
      bfct_pkg::S_INS: begin
        if (flags.key_gt) begin
          if (at_end) begin
            ev_start_d  = PW'(ent_start);
            ev_blocks_d = ent_size;
            status_d    = bfct_pkg::ST_EVICTED;
          end else begin
            mem_we = 1'b1;
          end
          if (!ptr_zero) begin
            ptr_d = ptr_dec;
          end
        end else begin
          if (at_end) begin
            ev_start_d  = PW'(key_start_q);
            ev_blocks_d = key_size_q;
            status_d    = bfct_pkg::ST_EVICTED;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = key_ent;
          end
          if (!full) begin
            count_d = count_q + CW'(1);
          end
          done_d = 1'b1;
        end
      end

      // Walk from the tail to the first entry large enough: the best fit.
      bfct_pkg::S_REQ: begin
        if (!flags.key_gt) begin
          granted_d   = PW'(ent_start);
          key_start_d = rem_start;
          key_size_d  = rem_size;
          reins_d     = (rem_size != '0);
          if (last) begin
            if (rem_size != '0) begin
              mem_we    = 1'b1;
              mem_waddr = ptr_q[AW-1:0];
              mem_wdata = {rem_start, rem_size};
            end else begin
              count_d = count_m1;
            end
            done_d = 1'b1;
          end else begin
            mem_raddr = ptr_inc[AW-1:0];
            ptr_d     = ptr_inc;
          end
        end else if (ptr_zero) begin
          status_d = bfct_pkg::ST_NO_FIT;
          done_d   = 1'b1;
        end else begin
          ptr_d = ptr_dec;
        end
      end

      bfct_pkg::S_FND: begin
        mem_raddr = ptr_inc[AW-1:0];
        ptr_d     = ptr_inc;
        if (last) begin
          if (flags.start_eq) begin
            count_d = count_m1;
          end else begin
            status_d = bfct_pkg::ST_NOT_FOUND;
          end
          done_d = 1'b1;
        end
      end

      // Close the gap by moving entries one slot forward. On a request the
      // remainder drops into the gap once a strictly smaller entry shows up.
      bfct_pkg::S_SHF: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_dec[AW-1:0];
        mem_raddr = ptr_inc[AW-1:0];
        if (reins_q && flags.key_gt) begin
          mem_wdata = key_ent;
          done_d    = 1'b1;
        end else if (last) begin
          if (!reins_q) begin
            count_d = count_m1;
            done_d  = 1'b1;
          end
        end else begin
          ptr_d = ptr_inc;
        end
      end

      bfct_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = key_ent;
        if (op_q == bfct_pkg::OP_INSERT && !full) begin
          count_d = count_q + CW'(1);
        end
        done_d = 1'b1;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfct_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    status_q    <= status_d;
    ptr_q       <= ptr_d;
    reins_q     <= reins_d;
    key_start_q <= key_start_d;
    key_size_q  <= key_size_d;
    granted_q   <= granted_d;
    ev_start_q  <= ev_start_d;
    ev_blocks_q <= ev_blocks_d;
  end

  assign busy             = (state_q != bfct_pkg::S_IDLE);
  assign result_valid_o   = done_q;
  assign status_o         = status_q;
  assign granted_start_o  = granted_q;
  assign evicted_start_o  = ev_start_q;
  assign evicted_blocks_o = ev_blocks_q;
  assign entry_count_o    = bfct_pkg::COUNT_PORT_BITS'(count_q);

endmodule

### hdl/bfct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfct_checker: port-level checks of the free chunk table
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
module bfct_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic [bfct_pkg::OP_BITS-1:0]         opcode_i,
  input logic [bfct_pkg::START_PORT_BITS-1:0] chunk_start_i,
  input logic [bfct_pkg::SIZE_BITS-1:0]       chunk_blocks_i,
  input logic                                 result_valid_o,
  input logic [1:0]                           status_o,
  input logic [bfct_pkg::START_PORT_BITS-1:0] granted_start_o,
  input logic [bfct_pkg::START_PORT_BITS-1:0] evicted_start_o,
  input logic [bfct_pkg::SIZE_BITS-1:0]       evicted_blocks_o,
  input logic [bfct_pkg::COUNT_PORT_BITS-1:0] entry_count_o
);

  // An accepted request either completes at once or holds the unit busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || result_valid_o)
    else $error("accepted request neither busy nor completed");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  // A quick request taken in the result cycle may strobe again right away;
  // without one, the strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !start |=> !result_valid_o)
    else $error("result strobe longer than one cycle without a new request");

  a_no_fit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == bfct_pkg::ST_NO_FIT |->
      granted_start_o == '0 && evicted_start_o == '0 && evicted_blocks_o == '0)
    else $error("failed request carries grant or eviction data");

  // A failed remove leaves the table as it was.
  a_not_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == bfct_pkg::ST_NOT_FOUND |->
      entry_count_o == $past(entry_count_o))
    else $error("entry count changed on a failed remove");

endmodule

bind best_fit_free_chunk_table_unit bfct_checker u_bfct_checker (.*);
